// ===== src/rac_pkg.sv =====
// shared types, codes and constants for the ricart-agrawala node controller
// no dependencies; used by rac_front, rac_back and the top level
package rac_pkg;

  localparam int ID_W          = 4;
  localparam int ID_NUM        = 16;
  localparam int STAMP_W       = 15;
  localparam int CNT_W         = 4;
  localparam int MAX_NODES_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 4;

  localparam logic [ID_W-1:0]  OWN_ID_RST         = 4'd1;
  localparam logic [ID_W-1:0]  NODE_COUNT_RST     = 4'd15;
  localparam logic [CNT_W-1:0] REPLIES_NEEDED_RST = 4'd14;

  typedef enum logic [1:0] {
    MODE_LOCAL_REQ = 2'd0,
    MODE_LOCAL_REL = 2'd1,
    MODE_IN_REQ    = 2'd2,
    MODE_IN_REP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MCAST = 2'd1,
    ACT_REPLY = 2'd2
  } act_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OWN_ID         = 2'd0,
    CFG_NODE_COUNT     = 2'd1,
    CFG_REPLIES_NEEDED = 2'd2
  } cfg_index_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  typedef struct packed {
    mode_t              mode;
    logic [ID_W-1:0]    peer;
    logic [STAMP_W-1:0] stamp;
    logic               peer_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic [ID_W-1:0]  own_id;
    logic [ID_W-1:0]  node_count;
    logic [CNT_W-1:0] replies_needed;
  } cfg_t;

endpackage

// ===== src/rac_front.sv =====
// front end: accepts input events, classifies them and holds them in a short queue
// depends on rac_pkg
module rac_front #(
  parameter int MAX_NODES = rac_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,  // mode
  input  logic [rac_pkg::IN_TDATA_W-1:0]  in_tdata,  // peer, stamp
  input  logic                            pop,
  output rac_pkg::head_t                  head
);

  localparam int PTR_W = $clog2(rac_pkg::QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(rac_pkg::QUEUE_DEPTH + 1);

  rac_pkg::cmd_t     queue_r [rac_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  rac_pkg::cmd_t     in_cmd;
  logic              push;
  logic              do_pop;

  always_comb begin
    in_cmd.mode    = rac_pkg::mode_t'(in_tuser);
    in_cmd.peer    = in_tdata[rac_pkg::ID_W-1:0];
    in_cmd.stamp   = in_tdata[rac_pkg::ID_W +: rac_pkg::STAMP_W];
    in_cmd.peer_ok = 32'(in_tdata[rac_pkg::ID_W-1:0]) < MAX_NODES;
  end

  assign in_tready = count_r != CNT_QW'(rac_pkg::QUEUE_DEPTH);
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

  assign head.valid = count_r != '0;
  assign head.cmd   = queue_r[rd_ptr_r];

endmodule

// ===== src/rac_back.sv =====
// back end: protocol state, event execution, release scan and output register
// depends on rac_pkg; fed by rac_front
module rac_back #(
  parameter int MAX_NODES = rac_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rac_pkg::head_t                  head,
  output logic                            pop,
  input  rac_pkg::cfg_t                   cfg,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [1:0]                      out_tuser,  // action
  output logic [rac_pkg::OUT_TDATA_W-1:0] out_tdata,  // target, granted, replies_remaining
  output logic                            out_tlast
);

  localparam int SCAN_N = (MAX_NODES < rac_pkg::ID_NUM) ? MAX_NODES : rac_pkg::ID_NUM;
  localparam int IDX_W  = $clog2(SCAN_N);
  localparam int PAD_W  = rac_pkg::OUT_TDATA_W - rac_pkg::ID_W - 1 - rac_pkg::CNT_W;

  rac_pkg::back_state_t state_r, state_nxt;

  logic                        requesting_r, requesting_nxt;
  logic [rac_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [MAX_NODES-1:0]        replied_r, replied_nxt;
  logic [rac_pkg::CNT_W-1:0]   awaiting_r, awaiting_nxt;
  logic [MAX_NODES-1:0]        deferred_r, deferred_nxt;
  logic [SCAN_N-1:0]           pending_r, pending_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;

  logic                        out_valid_r, out_valid_nxt;
  rac_pkg::act_t               out_action_r;
  logic [rac_pkg::ID_W-1:0]    out_target_r;
  logic                        out_granted_r;
  logic [rac_pkg::CNT_W-1:0]   out_remaining_r;
  logic                        out_last_r;

  logic                        out_free;
  logic [MAX_NODES-1:0]        pbit;
  logic [SCAN_N-1:0]           rel_pending;
  logic [SCAN_N-1:0]           idx_hot;
  logic [SCAN_N-1:0]           scan_rest;
  logic                        mine_greater;

  logic                        emit;
  rac_pkg::act_t               e_action;
  logic [rac_pkg::ID_W-1:0]    e_target;
  logic                        e_last;
  logic                        e_granted;
  logic [rac_pkg::CNT_W-1:0]   e_remaining;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      pbit[j] = 32'(head.cmd.peer) == j;
    end
    for (int j = 0; j < SCAN_N; j++) begin
      rel_pending[j] = deferred_r[j] && (j >= 1) && (j <= 32'(cfg.node_count));
      idx_hot[j]     = 32'(idx_r) == j;
    end
    scan_rest    = pending_r & ~idx_hot;
    mine_greater = (stamp_r > head.cmd.stamp) ||
                   ((stamp_r == head.cmd.stamp) && (cfg.own_id > head.cmd.peer));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rac_pkg::BK_IDLE: begin
        if (head.valid && out_free && head.cmd.mode == rac_pkg::MODE_LOCAL_REL &&
            rel_pending != '0) begin
          state_nxt = rac_pkg::BK_SCAN;
        end
      end
      rac_pkg::BK_SCAN: begin
        if (pending_r[idx_r] && out_free && scan_rest == '0) begin
          state_nxt = rac_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rac_pkg::BK_IDLE;
    endcase
  end

  // event execution and result selection
  always_comb begin
    requesting_nxt = requesting_r;
    stamp_nxt      = stamp_r;
    replied_nxt    = replied_r;
    awaiting_nxt   = awaiting_r;
    deferred_nxt   = deferred_r;
    pending_nxt    = pending_r;
    idx_nxt        = idx_r;
    pop            = 1'b0;
    emit           = 1'b0;
    e_action       = rac_pkg::ACT_NONE;
    e_target       = '0;
    e_last         = 1'b1;
    case (state_r)
      rac_pkg::BK_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          case (head.cmd.mode)
            rac_pkg::MODE_LOCAL_REQ: begin
              requesting_nxt = 1'b1;
              stamp_nxt      = head.cmd.stamp;
              replied_nxt    = '0;
              awaiting_nxt   = cfg.replies_needed;
              emit           = 1'b1;
              e_action       = rac_pkg::ACT_MCAST;
            end
            rac_pkg::MODE_LOCAL_REL: begin
              requesting_nxt = 1'b0;
              deferred_nxt   = '0;
              if (rel_pending == '0) begin
                emit = 1'b1;
              end else begin
                pending_nxt = rel_pending;
                idx_nxt     = IDX_W'(1);
              end
            end
            rac_pkg::MODE_IN_REQ: begin
              emit = 1'b1;
              if (requesting_r && !mine_greater && head.cmd.peer_ok) begin
                deferred_nxt = deferred_r | pbit;
              end else begin
                e_action = rac_pkg::ACT_REPLY;
                e_target = head.cmd.peer;
              end
            end
            rac_pkg::MODE_IN_REP: begin
              emit = 1'b1;
              if (head.cmd.peer_ok && (replied_r & pbit) == '0) begin
                replied_nxt = replied_r | pbit;
                if (awaiting_r != '0) begin
                  awaiting_nxt = awaiting_r - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      rac_pkg::BK_SCAN: begin
        if (pending_r[idx_r]) begin
          if (out_free) begin
            emit        = 1'b1;
            e_action    = rac_pkg::ACT_REPLY;
            e_target    = rac_pkg::ID_W'(idx_r);
            e_last      = scan_rest == '0;
            pending_nxt = scan_rest;
            idx_nxt     = idx_r + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
    e_granted     = requesting_nxt && (awaiting_nxt == '0);
    e_remaining   = awaiting_nxt;
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rac_pkg::BK_IDLE;
      requesting_r <= 1'b0;
      stamp_r      <= '0;
      replied_r    <= '0;
      awaiting_r   <= '0;
      deferred_r   <= '0;
      pending_r    <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      requesting_r <= requesting_nxt;
      stamp_r      <= stamp_nxt;
      replied_r    <= replied_nxt;
      awaiting_r   <= awaiting_nxt;
      deferred_r   <= deferred_nxt;
      pending_r    <= pending_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action_r    <= e_action;
      out_target_r    <= e_target;
      out_granted_r   <= e_granted;
      out_remaining_r <= e_remaining;
      out_last_r      <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_remaining_r, out_granted_r, out_target_r};

endmodule

// ===== src/ricart_agrawala_node_controller_top.sv =====
// top level of the ricart-agrawala node controller: configuration registers and wiring
// depends on rac_pkg, rac_front and rac_back
//
// One node's side of Ricart-Agrawala mutual exclusion. Each input transfer is one
// protocol event selected by in_tuser (local request, local release, incoming request,
// incoming reply). Events enter a four-entry queue and are executed one at a time by
// the back end. A local request, incoming request or incoming reply gives one result
// transfer. A local release walks the release scan counter from peer id 1 up to the
// highest deferred id no greater than node_count, giving one reply per such deferred
// peer with tlast on the final one, or a single no-action result when none is deferred.
// A stalled output holds the back end; the queue keeps taking events until it is full.
// Configuration writes are always ready and must be made while no event is in flight.
module ricart_agrawala_node_controller_top #(
  parameter int MAX_NODES = rac_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,  // mode
  input  logic [rac_pkg::IN_TDATA_W-1:0]  in_tdata,  // peer, stamp
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [1:0]                      out_tuser,  // action
  output logic [rac_pkg::OUT_TDATA_W-1:0] out_tdata,  // target, granted, replies_remaining
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rac_pkg::cfg_t  cfg_r, cfg_nxt;
  rac_pkg::head_t head;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (rac_pkg::cfg_index_t'(cfg_index))
        rac_pkg::CFG_OWN_ID:         cfg_nxt.own_id         = cfg_data;
        rac_pkg::CFG_NODE_COUNT:     cfg_nxt.node_count     = cfg_data;
        rac_pkg::CFG_REPLIES_NEEDED: cfg_nxt.replies_needed = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id         <= rac_pkg::OWN_ID_RST;
      cfg_r.node_count     <= rac_pkg::NODE_COUNT_RST;
      cfg_r.replies_needed <= rac_pkg::REPLIES_NEEDED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rac_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .pop      (pop),
    .head     (head)
  );

  rac_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // a multicast request is always the only result of its event
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rac_pkg::ACT_MCAST |-> out_tlast)
    else $error("multicast result without last marker");

  // grant only when no replies remain
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[8:5] == '0)
    else $error("granted with replies still awaited");

  // target is zero unless a reply is sent
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rac_pkg::ACT_REPLY |-> out_tdata[3:0] == '0)
    else $error("target set on a non-reply result");

endmodule

// ===== tb/tb_ricart_agrawala_node_controller_top.sv =====
// testbench for ricart_agrawala_node_controller_top: directed and random protocol events,
// results checked against an in-bench model of one node's mutual exclusion state
// depends on rac_pkg and the top level of the node controller
module tb_ricart_agrawala_node_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;

  typedef struct packed {
    rac_pkg::act_t action;
    logic [3:0]    target;
    logic          granted;
    logic [3:0]    remaining;
    logic          last;
  } node_msg_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [1:0]                      in_tuser = '0;
  logic [rac_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [1:0]                      out_tuser;
  logic [rac_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rac_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rac_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // shadow of the node's configuration and protocol state
  logic [3:0]  own_id = rac_pkg::OWN_ID_RST;
  logic [3:0]  node_count = rac_pkg::NODE_COUNT_RST;
  logic [3:0]  replies_needed = rac_pkg::REPLIES_NEEDED_RST;
  logic        requesting = 1'b0;
  logic [14:0] request_stamp = '0;
  logic [15:0] replied_mask = '0;
  logic [3:0]  awaiting_count = '0;
  logic [15:0] deferred_mask = '0;

  node_msg_t pending_msgs[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  ricart_agrawala_node_controller_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void add_msg(rac_pkg::act_t a, logic [3:0] t, logic last);
    node_msg_t m;
    m.action    = a;
    m.target    = t;
    m.granted   = requesting && (awaiting_count == 4'd0);
    m.remaining = awaiting_count;
    m.last      = last;
    pending_msgs.push_back(m);
  endfunction

  function automatic void predict_event(rac_pkg::mode_t m, logic [3:0] p, logic [14:0] s);
    int  hi;
    logic mine_greater;
    hi = 0;
    mine_greater = 1'b0;
    case (m)
      rac_pkg::MODE_LOCAL_REQ: begin
        requesting     = 1'b1;
        request_stamp  = s;
        replied_mask   = '0;
        awaiting_count = replies_needed;
        add_msg(rac_pkg::ACT_MCAST, 4'd0, 1'b1);
      end
      rac_pkg::MODE_LOCAL_REL: begin
        requesting = 1'b0;
        for (int i = 1; i <= int'(node_count); i++) begin
          if (deferred_mask[i]) hi = i;
        end
        for (int i = 1; i <= hi; i++) begin
          if (deferred_mask[i]) add_msg(rac_pkg::ACT_REPLY, 4'(i), i == hi);
        end
        deferred_mask = '0;
        if (hi == 0) add_msg(rac_pkg::ACT_NONE, 4'd0, 1'b1);
      end
      rac_pkg::MODE_IN_REQ: begin
        mine_greater = (request_stamp > s) || (request_stamp == s && own_id > p);
        if (!requesting || mine_greater) begin
          add_msg(rac_pkg::ACT_REPLY, p, 1'b1);
        end else begin
          deferred_mask[p] = 1'b1;
          add_msg(rac_pkg::ACT_NONE, 4'd0, 1'b1);
        end
      end
      default: begin
        if (!replied_mask[p]) begin
          replied_mask[p] = 1'b1;
          if (awaiting_count != 4'd0) awaiting_count = awaiting_count - 4'd1;
        end
        add_msg(rac_pkg::ACT_NONE, 4'd0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_event(rac_pkg::mode_t m, logic [3:0] p, logic [14:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {5'd0, s, p};
    predict_event(m, p, s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every expected transfer has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(logic [3:0] id, logic [3:0] nc, logic [3:0] rn);
    logic [3:0] vals[3];
    vals[0] = id;
    vals[1] = nc;
    vals[2] = rn;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= rac_pkg::cfg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    own_id         = id;
    node_count     = nc;
    replies_needed = rn;
  endtask

  // one request cycle: local request, peer traffic around its stamp, usually a release
  task automatic send_round(inout int sent);
    logic [14:0] s;
    logic [14:0] st;
    int          n_ev;
    s    = 15'($urandom_range(0, 32767));
    n_ev = $urandom_range(1, 14);
    send_event(rac_pkg::MODE_LOCAL_REQ, 4'($urandom_range(0, 15)), s);
    sent++;
    repeat (n_ev) begin
      case ($urandom_range(0, 3))
        0: st = s;
        1: st = s + 15'd1;
        2: st = s - 15'd1;
        default: st = 15'($urandom_range(0, 32767));
      endcase
      if ($urandom_range(0, 2) != 0)
        send_event(rac_pkg::MODE_IN_REQ, 4'($urandom_range(0, 15)), st);
      else
        send_event(rac_pkg::MODE_IN_REP, 4'($urandom_range(0, 15)), st);
      sent++;
    end
    if ($urandom_range(0, 9) != 0) begin
      send_event(rac_pkg::MODE_LOCAL_REL, 4'($urandom_range(0, 15)),
                 15'($urandom_range(0, 32767)));
      sent++;
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 12;
    recv_stall_pct = 69;
    write_config(4'd5, 4'd10, 4'd2);
    send_event(rac_pkg::MODE_LOCAL_REL, 4'd0, 15'd0);
    send_event(rac_pkg::MODE_IN_REQ, 4'd3, 15'd100);
    send_event(rac_pkg::MODE_IN_REP, 4'd4, 15'd0);
    send_event(rac_pkg::MODE_LOCAL_REQ, 4'd15, 15'd100);
    send_event(rac_pkg::MODE_IN_REQ, 4'd3, 15'd100);
    send_event(rac_pkg::MODE_IN_REQ, 4'd7, 15'd100);
    send_event(rac_pkg::MODE_IN_REQ, 4'd0, 15'd50);
    send_event(rac_pkg::MODE_IN_REQ, 4'd12, 15'd0);
    send_event(rac_pkg::MODE_IN_REQ, 4'd9, 15'd101);
    send_event(rac_pkg::MODE_IN_REQ, 4'd10, 15'd32767);
    send_event(rac_pkg::MODE_IN_REP, 4'd2, 15'd0);
    send_event(rac_pkg::MODE_IN_REP, 4'd2, 15'd0);
    send_event(rac_pkg::MODE_IN_REP, 4'd15, 15'd32767);
    send_event(rac_pkg::MODE_IN_REP, 4'd6, 15'd0);
    send_event(rac_pkg::MODE_LOCAL_REL, 4'd0, 15'd0);
    send_event(rac_pkg::MODE_LOCAL_REL, 4'd15, 15'd32767);
    send_event(rac_pkg::MODE_LOCAL_REQ, 4'd0, 15'd32767);
    send_event(rac_pkg::MODE_LOCAL_REQ, 4'd0, 15'd0);
    send_event(rac_pkg::MODE_IN_REQ, 4'd15, 15'd0);
    send_event(rac_pkg::MODE_IN_REQ, 4'd1, 15'd0);
    send_event(rac_pkg::MODE_LOCAL_REL, 4'd0, 15'd0);
    drain();
  endtask

  task automatic test_random_phase(int snd_pct, int rcv_pct, logic [3:0] id, logic [3:0] nc,
                                   logic [3:0] rn, int n_items);
    int sent;
    sent = 0;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    write_config(id, nc, rn);
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_round(sent);
      end else begin
        send_event(rac_pkg::mode_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   15'($urandom_range(0, 32767)));
        sent++;
      end
    end
    drain();
  endtask

  // receiver holds off while long release scans pile up behind the queue
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_config(4'd7, 4'd15, 4'd4);
    hold_req <= hold_req + 1;
    repeat (3) begin
      send_event(rac_pkg::MODE_LOCAL_REQ, 4'd0, 15'd20000);
      for (int i = 0; i < 16; i++) begin
        send_event(rac_pkg::MODE_IN_REQ, 4'(i), 15'd20000 + 15'(i % 3));
      end
      send_event(rac_pkg::MODE_LOCAL_REL, 4'd0, 15'd0);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    node_msg_t exp_msg;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_msgs.size() == 0) begin
        $error("unexpected result transfer: tuser %h tdata %h tlast %b", out_tuser,
               out_tdata, out_tlast);
        fail_count++;
      end else begin
        exp_msg = pending_msgs.pop_front();
        if (out_tuser != exp_msg.action) begin
          $error("action: expected %0d, got %0d", exp_msg.action, out_tuser);
          fail_count++;
        end
        if (out_tdata[3:0] != exp_msg.target) begin
          $error("target: expected %0d, got %0d", exp_msg.target, out_tdata[3:0]);
          fail_count++;
        end
        if (out_tdata[4] != exp_msg.granted) begin
          $error("granted: expected %0d, got %0d", exp_msg.granted, out_tdata[4]);
          fail_count++;
        end
        if (out_tdata[8:5] != exp_msg.remaining) begin
          $error("replies_remaining: expected %0d, got %0d", exp_msg.remaining,
                 out_tdata[8:5]);
          fail_count++;
        end
        if (out_tlast != exp_msg.last) begin
          $error("last_of_run: expected %0d, got %0d", exp_msg.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(12, 69, 4'd0, 4'd15, 4'd0, 110);
    test_random_phase(69, 12, 4'd15, 4'd0, 4'd15, 110);
    test_random_phase(0, 0, 4'd9, 4'd12, 4'd3, 110);
    test_backpressure();
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
